>>> rtl/lav_pkg.sv
// shared types and constants for the look-at view matrix core
// no dependencies
package lav_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ROOT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = 31;
  localparam int unsigned MUL_STEPS   = 13;
  localparam int unsigned NUM_LANES   = 5;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] offset;
    logic               last_row;
    logic               degenerate;
  } res_t;

  typedef struct packed {
    cmd_t cmd;
    logic degen;
  } entry_t;

endpackage

>>> rtl/look_at_view_matrix_core.sv
// the first row beat follows the command through the queue and the back end; rows come on
// back-to-back cycles; the back end takes a new command only after the last row of the one
// before, its pace set by the 32-step root and 31-step divide; a degenerate direction goes
// straight to the rows; the queue takes commands meanwhile
// results are strobes on valid_o and are never stalled
// asynchronous active-low reset empties the queue and idles the back end
module look_at_view_matrix_core #(
  parameter int unsigned QueueDepth = lav_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lav_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          valid_o,
  output lav_pkg::res_t res_o
);
  import lav_pkg::*;

  entry_t ent;
  logic   ent_valid, pop;

  lav_front #(.Depth(QueueDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .busy_o      (busy),
    .ent_valid_o (ent_valid),
    .ent_o       (ent),
    .pop_i       (pop)
  );

  lav_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_i       (ent),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

endmodule

>>> rtl/lav_front.sv
// front end: takes commands, flags degenerate directions, queues them
// depends on lav_pkg
module lav_front #(
  parameter int unsigned Depth = lav_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  lav_pkg::cmd_t   cmd_i,
  output logic            busy_o,
  output logic            ent_valid_o,
  output lav_pkg::entry_t ent_o,
  input  logic            pop_i
);
  import lav_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;
  entry_t            ent_in;

  assign busy_o      = (cnt_q == CntW'(Depth));
  assign push        = start_i && !busy_o;
  assign ent_valid_o = (cnt_q != '0);
  assign pop         = pop_i && ent_valid_o;
  assign ent_o       = mem_q[rd_ptr_q];

  always_comb begin
    ent_in.cmd   = cmd_i;
    // zero x and z: direction is null or along up
    ent_in.degen = (cmd_i.look_x == '0) && (cmd_i.look_z == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent_in;
    end
  end

endmodule

>>> rtl/lav_back.sv
// back end: square roots, divisions and products for one queued command, skipped for a
// degenerate direction, then three row beats; depends on lav_pkg
module lav_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ent_valid_i,
  input  lav_pkg::entry_t ent_i,
  output logic            pop_o,
  output logic            valid_o,
  output lav_pkg::res_t   res_o
);
  import lav_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ROOT, S_PREP, S_DIV, S_UNIT, S_MUL, S_EMIT
  } state_e;

  localparam logic signed [36:0] UNIT_MAX = 37'sd1073741824;
  localparam logic signed [36:0] UNIT_MIN = -37'sd1073741824;
  localparam logic signed [36:0] S32_MAX  = 37'sd2147483647;
  localparam logic signed [36:0] S32_MIN  = -37'sd2147483648;

  state_e      state_q;
  logic [5:0]  cnt_q;
  logic [1:0]  row_q;
  logic        valid_q;
  res_t        res_q;

  // datapath registers
  logic signed [31:0] p_q [3];
  logic [31:0]        mag_q [3];
  logic [2:0]         neg_q;
  logic               degen_q;
  logic [63:0]        sq_q, h2_q;
  logic [63:0]        rx_q [2], rr_q [2], rx_d [2], rr_d [2], trial [2];
  logic [63:0]        bit_q;
  logic [31:0]        rem_q [NUM_LANES], rem_d [NUM_LANES];
  logic [30:0]        dlo_q [NUM_LANES], quo_q [NUM_LANES];
  logic [31:0]        dv_q [NUM_LANES];
  logic               qbit [NUM_LANES];
  logic signed [31:0] f_q [3], u_q [3];
  logic signed [31:0] r0_q, r2_q;
  logic signed [31:0] off_q [3];
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod, prod_q;
  logic signed [65:0] acc_q, p_ext;

  function automatic logic signed [36:0] rnd30(input logic signed [65:0] v);
    logic [65:0] m;
    logic [35:0] q;
    m = v[65] ? unsigned'(-v) : unsigned'(v);
    q = 36'((m + (66'd1 << 29)) >> 30);
    return v[65] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [31:0] fin_unit(input logic signed [65:0] v);
    logic signed [36:0] r;
    r = rnd30(v);
    if (r > UNIT_MAX) r = UNIT_MAX;
    else if (r < UNIT_MIN) r = UNIT_MIN;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] fin_off(input logic signed [65:0] v);
    logic signed [36:0] r;
    r = rnd30(v);
    if (r > S32_MAX) r = S32_MAX;
    else if (r < S32_MIN) r = S32_MIN;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] to_unit(input logic [30:0] q, input logic neg);
    logic [31:0] m;
    m = (q > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, q};
    return neg ? -$signed(m) : $signed(m);
  endfunction

  assign pop_o   = (state_q == S_IDLE) && ent_valid_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // square root steps, lane 0 full length, lane 1 horizontal length
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = rr_q[i] + bit_q;
      if (rx_q[i] >= trial[i]) begin
        rx_d[i] = rx_q[i] - trial[i];
        rr_d[i] = (rr_q[i] >> 1) + bit_q;
      end else begin
        rx_d[i] = rx_q[i];
        rr_d[i] = rr_q[i] >> 1;
      end
    end
  end

  // restoring division, one quotient bit per lane per cycle
  always_comb begin
    logic [32:0] sh;
    for (int l = 0; l < NUM_LANES; l++) begin
      sh = {rem_q[l], dlo_q[l][30]};
      if (sh >= {1'b0, dv_q[l]}) begin
        rem_d[l] = 32'(sh - {1'b0, dv_q[l]});
        qbit[l]  = 1'b1;
      end else begin
        rem_d[l] = sh[31:0];
        qbit[l]  = 1'b0;
      end
    end
  end

  // operand schedule of the shared multiplier
  always_comb begin
    unique case (cnt_q)
      6'd0:    begin opa = r2_q;   opb = f_q[1]; end
      6'd1:    begin opa = r2_q;   opb = f_q[0]; end
      6'd2:    begin opa = r0_q;   opb = f_q[2]; end
      6'd3:    begin opa = r0_q;   opb = f_q[1]; end
      6'd4:    begin opa = r0_q;   opb = p_q[0]; end
      6'd5:    begin opa = r2_q;   opb = p_q[2]; end
      6'd6:    begin opa = u_q[0]; opb = p_q[0]; end
      6'd7:    begin opa = u_q[1]; opb = p_q[1]; end
      6'd8:    begin opa = u_q[2]; opb = p_q[2]; end
      6'd9:    begin opa = f_q[0]; opb = p_q[0]; end
      6'd10:   begin opa = f_q[1]; opb = p_q[1]; end
      6'd11:   begin opa = f_q[2]; opb = p_q[2]; end
      default: begin opa = '0;     opb = '0;     end
    endcase
    prod  = opa * opb;
    p_ext = $signed({{2{prod_q[63]}}, prod_q});
  end

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= ROW_RIGHT;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          row_q <= ROW_RIGHT;
          if (ent_valid_i) begin
            state_q <= ent_i.degen ? S_EMIT : S_SQ;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd3) begin
            cnt_q   <= '0;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(ROOT_STEPS - 1)) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            state_q <= S_UNIT;
          end
        end
        S_UNIT: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(MUL_STEPS)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          valid_q            <= 1'b1;
          res_q.row_index    <= row_q;
          res_q.last_row     <= (row_q == ROW_BACK);
          res_q.degenerate   <= degen_q;
          unique case (row_q)
            ROW_RIGHT: begin
              res_q.axis_x <= r0_q;
              res_q.axis_y <= '0;
              res_q.axis_z <= r2_q;
              res_q.offset <= off_q[0];
            end
            ROW_UP: begin
              res_q.axis_x <= u_q[0];
              res_q.axis_y <= u_q[1];
              res_q.axis_z <= u_q[2];
              res_q.offset <= off_q[1];
            end
            default: begin
              res_q.axis_x <= -f_q[0];
              res_q.axis_y <= -f_q[1];
              res_q.axis_z <= -f_q[2];
              res_q.offset <= off_q[2];
            end
          endcase
          row_q <= row_q + 1'b1;
          if (row_q == ROW_BACK) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (ent_valid_i) begin
          p_q[0]   <= ent_i.cmd.pos_x;
          p_q[1]   <= ent_i.cmd.pos_y;
          p_q[2]   <= ent_i.cmd.pos_z;
          mag_q[0] <= ent_i.cmd.look_x[31] ? 32'(-ent_i.cmd.look_x) : ent_i.cmd.look_x;
          mag_q[1] <= ent_i.cmd.look_y[31] ? 32'(-ent_i.cmd.look_y) : ent_i.cmd.look_y;
          mag_q[2] <= ent_i.cmd.look_z[31] ? 32'(-ent_i.cmd.look_z) : ent_i.cmd.look_z;
          neg_q    <= {ent_i.cmd.look_z[31], ent_i.cmd.look_y[31], ent_i.cmd.look_x[31]};
          degen_q  <= ent_i.degen;
          for (int j = 0; j < 3; j++) begin
            f_q[j]   <= '0;
            u_q[j]   <= '0;
            off_q[j] <= '0;
          end
          r0_q <= '0;
          r2_q <= '0;
        end
      end
      S_SQ: begin
        unique case (cnt_q)
          6'd0: sq_q <= mag_q[0] * mag_q[0];
          6'd1: begin
            sq_q <= mag_q[2] * mag_q[2];
            h2_q <= sq_q;
          end
          6'd2: begin
            sq_q <= mag_q[1] * mag_q[1];
            h2_q <= h2_q + sq_q;
          end
          default: begin
            rx_q[0] <= h2_q + sq_q;
            rx_q[1] <= h2_q;
            rr_q[0] <= '0;
            rr_q[1] <= '0;
            bit_q   <= 64'd1 << 62;
          end
        endcase
      end
      S_ROOT: begin
        for (int i = 0; i < 2; i++) begin
          rx_q[i] <= rx_d[i];
          rr_q[i] <= rr_d[i];
        end
        bit_q <= bit_q >> 2;
      end
      S_PREP: begin
        // lanes: f_x, f_y, f_z over full length; right x, z over horizontal length
        for (int l = 0; l < NUM_LANES; l++) begin
          logic [31:0] dv;
          logic [31:0] mg;
          logic [61:0] dvd;
          dv  = (l < 3) ? rr_q[0][31:0] : rr_q[1][31:0];
          mg  = (l == 0 || l == 4) ? mag_q[0] : ((l == 1) ? mag_q[1] : mag_q[2]);
          dvd = {mg, 30'b0} + {31'b0, dv[31:1]};
          dv_q[l]  <= dv;
          rem_q[l] <= {1'b0, dvd[61:31]};
          dlo_q[l] <= dvd[30:0];
          quo_q[l] <= '0;
        end
      end
      S_DIV: begin
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_q[l] <= rem_d[l];
          dlo_q[l] <= dlo_q[l] << 1;
          quo_q[l] <= {quo_q[l][29:0], qbit[l]};
        end
      end
      S_UNIT: begin
        f_q[0] <= to_unit(quo_q[0], neg_q[0]);
        f_q[1] <= to_unit(quo_q[1], neg_q[1]);
        f_q[2] <= to_unit(quo_q[2], neg_q[2]);
        // right x is -look_z over its length
        r0_q   <= to_unit(quo_q[3], !neg_q[2]);
        r2_q   <= to_unit(quo_q[4], neg_q[0]);
      end
      S_MUL: begin
        prod_q <= prod;
        unique case (cnt_q)
          6'd1: acc_q <= -p_ext;
          6'd2: begin
            u_q[0] <= fin_unit(acc_q);
            acc_q  <= p_ext;
          end
          6'd3: acc_q <= acc_q - p_ext;
          6'd4: begin
            u_q[1] <= fin_unit(acc_q);
            acc_q  <= p_ext;
          end
          6'd5: begin
            u_q[2] <= fin_unit(acc_q);
            acc_q  <= p_ext;
          end
          6'd7: begin
            off_q[0] <= fin_off(-acc_q);
            acc_q    <= p_ext;
          end
          6'd10: begin
            off_q[1] <= fin_off(-acc_q);
            acc_q    <= p_ext;
          end
          // third row axis is -f, so its offset is +dot(f, pos)
          6'd13: off_q[2] <= fin_off(acc_q);
          6'd6, 6'd8, 6'd9, 6'd11, 6'd12: acc_q <= acc_q + p_ext;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/lav_checker.sv
// port-level checks on row sequencing and degenerate beats of the look-at view matrix core
// depends on lav_pkg, bound to look_at_view_matrix_core
module lav_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          valid_o,
  input lav_pkg::res_t res_o
);
  import lav_pkg::*;

  a_right_then_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.row_index == ROW_RIGHT |=> valid_o && res_o.row_index == ROW_UP)
    else $error("up row did not follow right row");

  a_up_then_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.row_index == ROW_UP |=> valid_o && res_o.row_index == ROW_BACK)
    else $error("back row did not follow up row");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.last_row == (res_o.row_index == ROW_BACK)))
    else $error("last_row mismatch");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.degenerate |-> res_o.axis_x == '0 && res_o.axis_y == '0 &&
      res_o.axis_z == '0 && res_o.offset == '0)
    else $error("degenerate beat carries nonzero data");

  a_degen_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.row_index != ROW_RIGHT |-> $past(valid_o) &&
      res_o.degenerate == $past(res_o.degenerate))
    else $error("degenerate flag changed within a run");

endmodule

bind look_at_view_matrix_core lav_checker u_lav_checker (.*);

>>> dv/tb_look_at_view_matrix_core.sv
// testbench for look_at_view_matrix_core: directed and random camera commands,
// row beats checked field by field against an in-bench fixed-point predictor
// depends on rtl/lav_pkg.sv and rtl/look_at_view_matrix_core.sv
`timescale 1ns / 1ps

module tb_look_at_view_matrix_core;
  import lav_pkg::*;

  localparam longint OneQ30 = 64'sd1 << 30;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  cmd_t cmd_i = '0;
  logic busy;
  logic valid_o;
  res_t res_o;

  cmd_t   pending_cmds[$];
  res_t   expected_rows[$];
  int     n_errors = 0;
  int     n_rows = 0;
  int     n_degen = 0;
  int     n_sent = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;

  look_at_view_matrix_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned acc;
    longint unsigned bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= acc + bitv) begin
        x -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic longint to_unit(longint c, longint unsigned len);
    longint unsigned q;
    q = ((mag(c) << 30) + (len >> 1)) / len;
    if (q > OneQ30) q = OneQ30;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint rshift30(longint v);
    longint unsigned q;
    q = (mag(v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > OneQ30) return OneQ30;
    if (v < -OneQ30) return -OneQ30;
    return v;
  endfunction

  // builds the three row beats of one view matrix
  task automatic predict_view_rows(cmd_t c);
    longint p[3], d[3], f[3], r[3], u[3], ax[3][3], dot, off;
    longint unsigned h2, len, hlen;
    bit degen;
    res_t row;
    p[0] = c.pos_x; p[1] = c.pos_y; p[2] = c.pos_z;
    d[0] = c.look_x; d[1] = c.look_y; d[2] = c.look_z;
    degen = (d[0] == 0 && d[2] == 0);
    if (degen) n_degen++;
    for (int k = 0; k < 3; k++) begin
      row = '0;
      row.row_index = k[1:0];
      row.last_row = (k == 2);
      row.degenerate = degen;
      if (!degen) begin
        h2 = mag(d[0]) * mag(d[0]) + mag(d[2]) * mag(d[2]);
        len = int_root(h2 + mag(d[1]) * mag(d[1]));
        hlen = int_root(h2);
        for (int j = 0; j < 3; j++) f[j] = to_unit(d[j], len);
        r[0] = to_unit(-d[2], hlen);
        r[1] = 0;
        r[2] = to_unit(d[0], hlen);
        u[0] = clip_unit(rshift30(-(r[2] * f[1])));
        u[1] = clip_unit(rshift30(r[2] * f[0] - r[0] * f[2]));
        u[2] = clip_unit(rshift30(r[0] * f[1]));
        for (int j = 0; j < 3; j++) begin
          ax[0][j] = r[j];
          ax[1][j] = u[j];
          ax[2][j] = -f[j];
        end
        dot = ax[k][0] * p[0] + ax[k][1] * p[1] + ax[k][2] * p[2];
        off = rshift30(-dot);
        if (off > 64'sd2147483647) off = 64'sd2147483647;
        if (off < -64'sd2147483648) off = -64'sd2147483648;
        row.axis_x = ax[k][0][31:0];
        row.axis_y = ax[k][1][31:0];
        row.axis_z = ax[k][2][31:0];
        row.offset = off[31:0];
      end
      expected_rows.push_back(row);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at beat %0d: %s got %h expected %h", n_rows, what, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.pos_x = rand_q16(); c.pos_y = rand_q16(); c.pos_z = rand_q16();
    c.look_x = rand_q16(); c.look_y = rand_q16(); c.look_z = rand_q16();
    // parallel to up now and then
    if ($urandom_range(0, 15) == 0) begin
      c.look_x = '0;
      c.look_z = '0;
    end
    return c;
  endfunction

  function automatic cmd_t mk(logic [31:0] px, py, pz, lx, ly, lz);
    cmd_t c;
    c.pos_x = px; c.pos_y = py; c.pos_z = pz;
    c.look_x = lx; c.look_y = ly; c.look_z = lz;
    return c;
  endfunction

  initial begin
    pending_cmds.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(32'h1_0000, 32'h2_0000, 32'h3_0000, 0, 32'h1_0000, 0));
    pending_cmds.push_back(mk(32'h5_0000, 0, 32'h5_0000, 0, 32'hffff_0000, 0));
    pending_cmds.push_back(mk(0, 0, 32'h5_0000, 0, 0, 32'hffff_0000));
    pending_cmds.push_back(mk(32'h1_0000, 0, 0, 32'h1_0000, 0, 0));
    pending_cmds.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_cmds.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_cmds.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    pending_cmds.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    pending_cmds.push_back(mk(32'h7fff_ffff, 0, 0, 0, 0, 1));
    pending_cmds.push_back(mk(0, 32'h8000_0000, 0, 32'hffff_ffff, 0, 0));
    pending_cmds.push_back(mk(32'h1234_5678, 32'h9abc_def0, 32'hffff_ffff,
                              1, 32'h7fff_ffff, 1));
    pending_cmds.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    pending_cmds.push_back(mk(32'h3_0000, 32'h4_0000, 32'h5_0000,
                              32'h3_0000, 32'h4_0000, 32'h5_0000));
    for (int i = 0; i < 240; i++) pending_cmds.push_back(rand_cmd());
  end

  // sender: bursts and gaps, one hold-off until drained midway
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_view_rows(cmd_i);
        n_sent++;
        if (n_sent == 120) hold_off <= 1'b1;
      end
      if (hold_off && expected_rows.size() == 0 && !(start && !busy)) hold_off <= 1'b0;
      if (start && busy) begin
        // command still waiting to be taken
      end else if (pending_cmds.size() == 0 || hold_off || (n_sent == 120 && start)) begin
        start <= 1'b0;
        if (pending_cmds.size() == 0 && !(start && !busy) || pending_cmds.size() == 0)
          stim_done <= (pending_cmds.size() == 0);
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        start <= 1'b1;
        cmd_i <= pending_cmds.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor: compare each row beat with the oldest expected row
  always @(posedge clk_i) begin
    res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_o) begin
      if (expected_rows.size() == 0) begin
        $display("unexpected row beat %0d", n_rows);
        n_errors++;
      end else begin
        want = expected_rows.pop_front();
        if (res_o.row_index !== want.row_index)
          report_mismatch("row_index", res_o.row_index, want.row_index);
        if (res_o.axis_x !== want.axis_x) report_mismatch("axis_x", res_o.axis_x, want.axis_x);
        if (res_o.axis_y !== want.axis_y) report_mismatch("axis_y", res_o.axis_y, want.axis_y);
        if (res_o.axis_z !== want.axis_z) report_mismatch("axis_z", res_o.axis_z, want.axis_z);
        if (res_o.offset !== want.offset) report_mismatch("offset", res_o.offset, want.offset);
        if (res_o.last_row !== want.last_row)
          report_mismatch("last_row", res_o.last_row, want.last_row);
        if (res_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", res_o.degenerate, want.degenerate);
      end
      n_rows <= n_rows + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && !start && expected_rows.size() == 0)
           && cycle_count < CycleLimit)
      @(posedge clk_i);
    if (cycle_count < CycleLimit) repeat (200) @(posedge clk_i);
    $display("covered %0d commands (%0d degenerate), %0d row beats checked",
             n_sent, n_degen, n_rows);
    if (cycle_count < CycleLimit && n_errors == 0 && expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
